// ----- sv/cedpb_pkg.sv -----
// Package for the card event dedup and poll back-off block.
// Holds the item, result and register types, register indexes and card kind codes.
// No dependencies.
package cedpb_pkg;

    localparam int UID_LO_W   = 64;
    localparam int UID_HI_W   = 16;
    localparam int UID_LEN_W  = 4;
    localparam int TIME_W     = 63;
    localparam int SAK_W      = 8;
    localparam int KIND_W     = 3;
    localparam int DELAY_W    = 19;
    localparam int WINDOW_W   = 32;
    localparam int COUNT_W    = 8;
    localparam int INTERVAL_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int UID_BYTES  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_DEDUP_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_FORGET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_IDLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWER_IDLE  = 3'd4;

    localparam logic [WINDOW_W-1:0]   RST_DEDUP_WINDOW  = 32'd1500000;
    localparam logic [COUNT_W-1:0]    RST_IDLE_FORGET   = 8'd3;
    localparam logic [INTERVAL_W-1:0] RST_POLL_INTERVAL = 16'd300;
    localparam logic [COUNT_W-1:0]    RST_SLOW_IDLE     = 8'd10;
    localparam logic [COUNT_W-1:0]    RST_SLOWER_IDLE   = 8'd30;
    localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL  = 16'd300;
    localparam logic [COUNT_W-1:0]    COUNT_MAX         = 8'd255;

    localparam logic [SAK_W-1:0] SAK_CLASSIC1K  = 8'h08;
    localparam logic [SAK_W-1:0] SAK_CLASSIC4K  = 8'h18;
    localparam logic [SAK_W-1:0] SAK_ULTRALIGHT = 8'h00;
    localparam logic [SAK_W-1:0] SAK_PLUS_A     = 8'h10;
    localparam logic [SAK_W-1:0] SAK_PLUS_B     = 8'h11;
    localparam int               SAK_ISO4_BIT   = 5;

    localparam logic [KIND_W-1:0] KIND_CLASSIC1K  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLASSIC4K  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ULTRALIGHT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PLUS       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ISO4       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 3'd5;

    typedef struct packed {
        logic [WINDOW_W-1:0]   dedup_window_us;
        logic [COUNT_W-1:0]    idle_forget_count;
        logic [INTERVAL_W-1:0] base_interval_ms;
        logic [COUNT_W-1:0]    slow_idle_threshold;
        logic [COUNT_W-1:0]    slower_idle_threshold;
    } t_cfg;

    typedef struct packed {
        logic                 card_present;
        logic [SAK_W-1:0]     sak;
        logic [UID_LO_W-1:0]  uid_low;
        logic [UID_HI_W-1:0]  uid_high;
        logic [UID_LEN_W-1:0] uid_length;
        logic [TIME_W-1:0]    time_us;
    } t_item;

    typedef struct packed {
        logic                 card_event;
        logic [KIND_W-1:0]    card_kind;
        logic [UID_LO_W-1:0]  event_uid_low;
        logic [UID_HI_W-1:0]  event_uid_high;
        logic [UID_LEN_W-1:0] event_uid_length;
        logic [DELAY_W-1:0]   next_delay_ms;
    } t_result;

    function automatic logic [KIND_W-1:0] classify(input logic [SAK_W-1:0] sak);
        logic [KIND_W-1:0] kind;
        case (sak)
            SAK_CLASSIC1K:          kind = KIND_CLASSIC1K;
            SAK_CLASSIC4K:          kind = KIND_CLASSIC4K;
            SAK_ULTRALIGHT:         kind = KIND_ULTRALIGHT;
            SAK_PLUS_A, SAK_PLUS_B: kind = KIND_PLUS;
            default: begin
                kind = sak[SAK_ISO4_BIT] ? KIND_ISO4 : KIND_UNKNOWN;
            end
        endcase
        return kind;
    endfunction

endpackage

// ----- sv/cedpb_cfg.sv -----
// Configuration registers of the card event dedup and poll back-off block.
// Depends on cedpb_pkg for register indexes, reset values and t_cfg.
module cedpb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cedpb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cedpb_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output cedpb_pkg::t_cfg                     o_cfg
);
    import cedpb_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dedup_window_us       <= RST_DEDUP_WINDOW;
            r_cfg.idle_forget_count     <= RST_IDLE_FORGET;
            r_cfg.base_interval_ms      <= RST_POLL_INTERVAL;
            r_cfg.slow_idle_threshold   <= RST_SLOW_IDLE;
            r_cfg.slower_idle_threshold <= RST_SLOWER_IDLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEDUP_WINDOW:  r_cfg.dedup_window_us <= i_cfg_wdata[WINDOW_W-1:0];
                REG_IDLE_FORGET:   r_cfg.idle_forget_count <= i_cfg_wdata[COUNT_W-1:0];
                REG_POLL_INTERVAL: r_cfg.base_interval_ms <= i_cfg_wdata[INTERVAL_W-1:0];
                REG_SLOW_IDLE:     r_cfg.slow_idle_threshold <= i_cfg_wdata[COUNT_W-1:0];
                REG_SLOWER_IDLE:   r_cfg.slower_idle_threshold <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/cedpb_eval.sv -----
// Evaluation of one poll result: UID dedup, idle counting and delay tiering.
// Holds the last reported UID, report time and empty poll count.
// Depends on cedpb_pkg for t_item, t_result, t_cfg and classify.
module cedpb_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  cedpb_pkg::t_item    i_item,
    input  cedpb_pkg::t_cfg     i_cfg,
    output cedpb_pkg::t_result  o_res
);
    import cedpb_pkg::*;

    logic [UID_LO_W-1:0]  r_last_lo,  n_last_lo;
    logic [UID_HI_W-1:0]  r_last_hi,  n_last_hi;
    logic [UID_LEN_W-1:0] r_last_len, n_last_len;
    logic [TIME_W-1:0]    r_last_time, n_last_time;
    logic [COUNT_W-1:0]   r_empty,    n_empty;

    logic [INTERVAL_W-1:0]      base;
    logic [INTERVAL_W+1:0]      base_x3;
    logic [TIME_W-1:0]          diff;
    logic                       elapsed;
    logic [UID_BYTES*8-1:0]     uid_new;
    logic [UID_BYTES*8-1:0]     uid_old;
    logic [UID_BYTES-1:0]       byte_eq;
    logic                       same;
    logic [COUNT_W-1:0]         count_inc;

    assign base    = (i_cfg.base_interval_ms == '0) ? DEFAULT_INTERVAL : i_cfg.base_interval_ms;
    assign base_x3 = {2'b00, base} + {1'b0, base, 1'b0};

    assign diff    = i_item.time_us - r_last_time;
    assign elapsed = !diff[TIME_W-1] &&
                     (diff > {{(TIME_W-WINDOW_W){1'b0}}, i_cfg.dedup_window_us});

    assign uid_new = {i_item.uid_high, i_item.uid_low};
    assign uid_old = {r_last_hi, r_last_lo};

    always_comb begin
        for (int i = 0; i < UID_BYTES; i++) begin
            byte_eq[i] = (i_item.uid_length <= UID_LEN_W'(i)) ||
                         (uid_new[i*8 +: 8] == uid_old[i*8 +: 8]);
        end
    end

    assign same      = (i_item.uid_length == r_last_len) && (&byte_eq);
    assign count_inc = (r_empty == COUNT_MAX) ? r_empty : r_empty + 1'b1;

    always_comb begin
        n_last_lo   = r_last_lo;
        n_last_hi   = r_last_hi;
        n_last_len  = r_last_len;
        n_last_time = r_last_time;
        n_empty     = r_empty;
        o_res       = '0;
        o_res.card_kind = KIND_UNKNOWN;
        if (i_item.card_present) begin
            n_empty         = '0;
            o_res.card_kind = classify(i_item.sak);
            if (!same || elapsed) begin
                o_res.card_event       = 1'b1;
                o_res.event_uid_low    = i_item.uid_low;
                o_res.event_uid_high   = i_item.uid_high;
                o_res.event_uid_length = i_item.uid_length;
                n_last_lo   = i_item.uid_low;
                n_last_hi   = i_item.uid_high;
                n_last_len  = i_item.uid_length;
                n_last_time = i_item.time_us;
            end
            o_res.next_delay_ms = DELAY_W'(base);
        end else begin
            n_empty = count_inc;
            if ((r_empty != COUNT_MAX) && (count_inc == i_cfg.idle_forget_count)) begin
                n_last_lo  = '0;
                n_last_hi  = '0;
                n_last_len = '0;
            end
            if (count_inc < i_cfg.slow_idle_threshold) begin
                o_res.next_delay_ms = DELAY_W'(base);
            end else if (count_inc < i_cfg.slower_idle_threshold) begin
                o_res.next_delay_ms = DELAY_W'(base_x3);
            end else begin
                o_res.next_delay_ms = {base_x3, 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_lo   <= '0;
            r_last_hi   <= '0;
            r_last_len  <= '0;
            r_last_time <= '0;
            r_empty     <= '0;
        end else if (i_go) begin
            r_last_lo   <= n_last_lo;
            r_last_hi   <= n_last_hi;
            r_last_len  <= n_last_len;
            r_last_time <= n_last_time;
            r_empty     <= n_empty;
        end
    end

endmodule

// ----- sv/card_event_dedup_and_poll_backoff.sv -----
// Top level of the card event dedup and poll back-off block.
// Input register, evaluation stage and result register with valid/ready on both sides.
// Depends on cedpb_pkg, cedpb_cfg and cedpb_eval.
//
// Usage:
//   Input channel i_valid/o_ready carries one poll result per transfer:
//   card presence, SAK, UID (low 64 bits, high 16 bits, length) and time.
//   Output channel o_valid/i_ready carries one result per input transfer:
//   card event flag, card kind, reported UID and next poll delay.
//   The user writes configuration through i_cfg_we/i_cfg_idx/i_cfg_wdata while idle;
//   the block does not enforce it. An accepted item waits in the input register;
//   when it advances, the evaluation logic loads the result register, sets o_valid,
//   and updates the dedup state at the same edge. Throughput is one item per cycle
//   while the receiver does not stall; the next item sees the state left by the
//   previous one because state and result update together.
//   When the receiver stalls the result register holds, the input register
//   fills, and o_ready drops only when both are full.
//   Reset clears both valid flags, the stored UID, report time and empty
//   count, and loads the register defaults.
module card_event_dedup_and_poll_backoff (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cedpb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cedpb_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_card_present,
    input  logic [cedpb_pkg::SAK_W-1:0]          i_sak,
    input  logic [cedpb_pkg::UID_LO_W-1:0]       i_uid_low,
    input  logic [cedpb_pkg::UID_HI_W-1:0]       i_uid_high,
    input  logic [cedpb_pkg::UID_LEN_W-1:0]      i_uid_length,
    input  logic [cedpb_pkg::TIME_W-1:0]         i_time_us,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_card_event,
    output logic [cedpb_pkg::KIND_W-1:0]         o_card_kind,
    output logic [cedpb_pkg::UID_LO_W-1:0]       o_event_uid_low,
    output logic [cedpb_pkg::UID_HI_W-1:0]       o_event_uid_high,
    output logic [cedpb_pkg::UID_LEN_W-1:0]      o_event_uid_length,
    output logic [cedpb_pkg::DELAY_W-1:0]        o_next_delay_ms
);
    import cedpb_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    t_result res;
    t_result r_out;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;
    logic    in_xfer;

    cedpb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    cedpb_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.card_present <= i_card_present;
            r_in.sak          <= i_sak;
            r_in.uid_low      <= i_uid_low;
            r_in.uid_high     <= i_uid_high;
            r_in.uid_length   <= i_uid_length;
            r_in.time_us      <= i_time_us;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_card_event       = r_out.card_event;
    assign o_card_kind        = r_out.card_kind;
    assign o_event_uid_low    = r_out.event_uid_low;
    assign o_event_uid_high   = r_out.event_uid_high;
    assign o_event_uid_length = r_out.event_uid_length;
    assign o_next_delay_ms    = r_out.next_delay_ms;

endmodule

// ----- bench/tb_card_event_dedup_and_poll_backoff.sv -----
// Testbench for card_event_dedup_and_poll_backoff: directed, register-extreme, idle-saturation
// and random poll sequences, each result checked against a cycle-free prediction of the dedup and
// back-off rules. Depends on cedpb_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_card_event_dedup_and_poll_backoff;
    import cedpb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_card_present = 1'b0;
    logic [SAK_W-1:0]      i_sak = '0;
    logic [UID_LO_W-1:0]   i_uid_low = '0;
    logic [UID_HI_W-1:0]   i_uid_high = '0;
    logic [UID_LEN_W-1:0]  i_uid_length = '0;
    logic [TIME_W-1:0]     i_time_us = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_card_event;
    logic [KIND_W-1:0]     o_card_kind;
    logic [UID_LO_W-1:0]   o_event_uid_low;
    logic [UID_HI_W-1:0]   o_event_uid_high;
    logic [UID_LEN_W-1:0]  o_event_uid_length;
    logic [DELAY_W-1:0]    o_next_delay_ms;

    card_event_dedup_and_poll_backoff DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_card_present     (i_card_present),
        .i_sak              (i_sak),
        .i_uid_low          (i_uid_low),
        .i_uid_high         (i_uid_high),
        .i_uid_length       (i_uid_length),
        .i_time_us          (i_time_us),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_card_event       (o_card_event),
        .o_card_kind        (o_card_kind),
        .o_event_uid_low    (o_event_uid_low),
        .o_event_uid_high   (o_event_uid_high),
        .o_event_uid_length (o_event_uid_length),
        .o_next_delay_ms    (o_next_delay_ms)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted register file and dedup state
    t_cfg                 cfg;
    logic [UID_LO_W-1:0]  last_lo = '0;
    logic [UID_HI_W-1:0]  last_hi = '0;
    logic [UID_LEN_W-1:0] last_len = '0;
    logic [TIME_W-1:0]    last_report = '0;
    logic [COUNT_W-1:0]   empty_run = '0;

    t_result expected_reports[$];
    int n_errors = 0;
    int gap_max = 0;
    int stall_max = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    logic [TIME_W-1:0] poll_clock = '0;

    logic [UID_LO_W-1:0]  card_lo[4];
    logic [UID_HI_W-1:0]  card_hi[4];
    logic [UID_LEN_W-1:0] card_len[4];
    logic [SAK_W-1:0]     card_sak[4];

    function automatic logic [KIND_W-1:0] kind_of(input logic [SAK_W-1:0] sak);
        if (sak == SAK_CLASSIC1K) return KIND_CLASSIC1K;
        if (sak == SAK_CLASSIC4K) return KIND_CLASSIC4K;
        if (sak == SAK_ULTRALIGHT) return KIND_ULTRALIGHT;
        if (sak == SAK_PLUS_A || sak == SAK_PLUS_B) return KIND_PLUS;
        if (sak[SAK_ISO4_BIT]) return KIND_ISO4;
        return KIND_UNKNOWN;
    endfunction

    function automatic t_result predict_poll(input t_item p);
        t_result r;
        logic [DELAY_W-1:0] base;
        logic [TIME_W-1:0]  since;
        logic [79:0]        keep;
        logic               same, aged;
        int                 n;
        r = '0;
        r.card_kind = KIND_UNKNOWN;
        base = DELAY_W'((cfg.base_interval_ms == '0) ? DEFAULT_INTERVAL : cfg.base_interval_ms);
        if (p.card_present) begin
            since = p.time_us - last_report;
            aged = !since[TIME_W-1] && (since > cfg.dedup_window_us);
            n = (p.uid_length > UID_BYTES) ? UID_BYTES : p.uid_length;
            keep = (80'd1 << (8 * n)) - 80'd1;
            same = (p.uid_length == last_len) &&
                   ((({p.uid_high, p.uid_low} ^ {last_hi, last_lo}) & keep) == '0);
            empty_run = '0;
            r.card_kind = kind_of(p.sak);
            if (!same || aged) begin
                r.card_event = 1'b1;
                r.event_uid_low = p.uid_low;
                r.event_uid_high = p.uid_high;
                r.event_uid_length = p.uid_length;
                last_lo = p.uid_low;
                last_hi = p.uid_high;
                last_len = p.uid_length;
                last_report = p.time_us;
            end
            r.next_delay_ms = base;
        end else begin
            if (empty_run != COUNT_MAX) begin
                empty_run++;
                if (empty_run == cfg.idle_forget_count) begin
                    last_lo = '0;
                    last_hi = '0;
                    last_len = '0;
                end
            end
            if (empty_run < cfg.slow_idle_threshold) r.next_delay_ms = base;
            else if (empty_run < cfg.slower_idle_threshold) r.next_delay_ms = DELAY_W'(base * 3);
            else r.next_delay_ms = DELAY_W'(base * 6);
        end
        return r;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DEDUP_WINDOW:  cfg.dedup_window_us = data[WINDOW_W-1:0];
            REG_IDLE_FORGET:   cfg.idle_forget_count = data[COUNT_W-1:0];
            REG_POLL_INTERVAL: cfg.base_interval_ms = data[INTERVAL_W-1:0];
            REG_SLOW_IDLE:     cfg.slow_idle_threshold = data[COUNT_W-1:0];
            REG_SLOWER_IDLE:   cfg.slower_idle_threshold = data[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_item make_poll(input logic present, input logic [SAK_W-1:0] sak,
                                        input logic [UID_LO_W-1:0] lo,
                                        input logic [UID_HI_W-1:0] hi,
                                        input logic [UID_LEN_W-1:0] len,
                                        input logic [TIME_W-1:0] t);
        t_item p;
        p.card_present = present;
        p.sak = sak;
        p.uid_low = lo;
        p.uid_high = hi;
        p.uid_length = len;
        p.time_us = t;
        return p;
    endfunction

    function automatic t_item card_poll(input int slot, input logic [TIME_W-1:0] t);
        return make_poll(1'b1, card_sak[slot], card_lo[slot], card_hi[slot], card_len[slot], t);
    endfunction

    function automatic t_item empty_poll(input logic [TIME_W-1:0] t);
        return make_poll(1'b0, SAK_W'($urandom), {$urandom, $urandom}, UID_HI_W'($urandom),
                         UID_LEN_W'($urandom), t);
    endfunction

    function automatic void new_card(input int slot);
        logic [79:0]          bytes;
        logic [UID_LEN_W-1:0] len;
        case ($urandom_range(0, 2))
            0:       len = 4'd4;
            1:       len = 4'd7;
            default: len = 4'd10;
        endcase
        bytes = 80'({$urandom, $urandom, $urandom});
        bytes &= (80'd1 << (8 * len)) - 80'd1;
        card_lo[slot] = bytes[63:0];
        card_hi[slot] = bytes[79:64];
        card_len[slot] = len;
        case ($urandom_range(0, 7))
            0:       card_sak[slot] = SAK_CLASSIC1K;
            1:       card_sak[slot] = SAK_CLASSIC4K;
            2:       card_sak[slot] = SAK_ULTRALIGHT;
            3:       card_sak[slot] = SAK_PLUS_A;
            4:       card_sak[slot] = SAK_PLUS_B;
            5:       card_sak[slot] = 8'h20;
            default: card_sak[slot] = SAK_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] time_step();
        longint unsigned w;
        w = cfg.dedup_window_us;
        if (w < 1000000) return TIME_W'($urandom_range(0, 2 * w + 2));
        return TIME_W'($urandom_range(0, 3000000));
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        case ($urandom_range(0, 5))
            0:       c.dedup_window_us = '0;
            1:       c.dedup_window_us = 32'd1;
            2:       c.dedup_window_us = RST_DEDUP_WINDOW;
            3:       c.dedup_window_us = '1;
            4:       c.dedup_window_us = $urandom;
            default: c.dedup_window_us = $urandom_range(0, 5000);
        endcase
        case ($urandom_range(0, 3))
            0:       c.idle_forget_count = '0;
            1:       c.idle_forget_count = 8'd1;
            2:       c.idle_forget_count = COUNT_MAX;
            default: c.idle_forget_count = COUNT_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 4))
            0:       c.base_interval_ms = '0;
            1:       c.base_interval_ms = 16'd1;
            2:       c.base_interval_ms = '1;
            3:       c.base_interval_ms = INTERVAL_W'($urandom);
            default: c.base_interval_ms = INTERVAL_W'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(0, 3))
            0:       c.slow_idle_threshold = '0;
            1:       c.slow_idle_threshold = COUNT_MAX;
            default: c.slow_idle_threshold = COUNT_W'($urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 3))
            0:       c.slower_idle_threshold = '0;
            1:       c.slower_idle_threshold = COUNT_MAX;
            default: c.slower_idle_threshold = COUNT_W'($urandom_range(0, 40));
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // block must be idle; upper bits of narrow registers carry noise
    task automatic load_config(input t_cfg c);
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
        write_reg(REG_DEDUP_WINDOW, c.dedup_window_us);
        write_reg(REG_IDLE_FORGET, {24'($urandom), c.idle_forget_count});
        write_reg(REG_POLL_INTERVAL, {16'($urandom), c.base_interval_ms});
        write_reg(REG_SLOW_IDLE, {24'($urandom), c.slow_idle_threshold});
        write_reg(REG_SLOWER_IDLE, {24'($urandom), c.slower_idle_threshold});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_poll(input t_item p);
        i_valid <= 1'b1;
        i_card_present <= p.card_present;
        i_sak <= p.sak;
        i_uid_low <= p.uid_low;
        i_uid_high <= p.uid_high;
        i_uid_length <= p.uid_length;
        i_time_us <= p.time_us;
        do @(posedge i_clk); while (!o_ready);
        expected_reports.push_back(predict_poll(p));
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (gap_max != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [UID_LO_W-1:0] uid_a;
        logic [UID_LO_W-1:0] uid_b;
        logic [TIME_W-1:0]   t;
        uid_a = 64'h0000_0000_1122_3344;
        uid_b = 64'h00AA_BBCC_DDEE_FF01;
        gap_max = 0;
        stall_max = 3;
        // empty UID of length zero matches the cleared state at time zero
        send_poll(make_poll(1'b1, SAK_CLASSIC1K, '0, '0, 4'd0, '0));
        send_poll(make_poll(1'b1, SAK_CLASSIC4K, uid_a, '0, 4'd4, 63'd10));
        send_poll(make_poll(1'b1, SAK_CLASSIC4K, uid_a, '0, 4'd4, 63'd20));
        send_poll(make_poll(1'b1, SAK_CLASSIC4K, uid_a, '0, 4'd4, 63'd10 + RST_DEDUP_WINDOW));
        t = 63'd11 + RST_DEDUP_WINDOW;
        send_poll(make_poll(1'b1, SAK_CLASSIC4K, uid_a, '0, 4'd4, t));
        send_poll(make_poll(1'b1, SAK_CLASSIC4K, uid_a, '0, 4'd4, 63'd5));
        send_poll(make_poll(1'b1, SAK_ULTRALIGHT, uid_b, '0, 4'd7, t + 63'd10));
        send_poll(make_poll(1'b1, SAK_PLUS_A, uid_b, '0, 4'd7, t + 63'd20));
        send_poll(make_poll(1'b1, SAK_PLUS_B, uid_b & 64'hFFFF_FFFF, '0, 4'd4, t + 63'd30));
        send_poll(make_poll(1'b1, 8'h20, '1, '1, 4'd10, t + 63'd40));
        send_poll(make_poll(1'b1, 8'hFF, '1, '1, 4'd10, t + 63'd50));
        send_poll(make_poll(1'b1, 8'hDF, '1, '1, 4'd10, t + 63'd60));
        send_poll(make_poll(1'b1, 8'h01, '1, '1, 4'd15, t + 63'd70));
        send_poll(make_poll(1'b1, 8'h28, '1, '1, 4'd15, t + 63'd80));
        repeat (3) send_poll(empty_poll(t + 63'd90));
        send_poll(make_poll(1'b1, 8'h28, '1, '1, 4'd15, t + 63'd100));
        send_poll(make_poll(1'b1, SAK_CLASSIC1K, uid_a, '0, 4'd4, '1));
        send_poll(make_poll(1'b1, SAK_CLASSIC1K, uid_a, '0, 4'd4, '0));
        send_poll(make_poll(1'b1, SAK_CLASSIC1K, uid_a, '0, 4'd4, RST_DEDUP_WINDOW));
        send_poll(make_poll(1'b1, SAK_CLASSIC1K, uid_a, '0, 4'd4, 63'h4000_0000_0000_0000));
        send_poll(make_poll(1'b1, SAK_CLASSIC1K, uid_a, '0, 4'd4, '0));
        poll_clock = 63'd5_000_000;
    endtask

    task automatic test_register_extremes();
        logic [TIME_W-1:0] t;
        drain();
        gap_max = 0;
        stall_max = 0;
        load_config('{dedup_window_us: '0, idle_forget_count: '0, base_interval_ms: '0,
                      slow_idle_threshold: '0, slower_idle_threshold: '0});
        new_card(1);
        t = poll_clock;
        send_poll(card_poll(1, t));
        send_poll(card_poll(1, t));
        send_poll(card_poll(1, t + 63'd1));
        repeat (4) send_poll(empty_poll(t + 63'd1));
        send_poll(card_poll(1, t + 63'd1));
        drain();
        load_config('{dedup_window_us: '1, idle_forget_count: 8'd1, base_interval_ms: '1,
                      slow_idle_threshold: COUNT_MAX, slower_idle_threshold: 8'd1});
        send_poll(empty_poll(t + 63'd2));
        send_poll(card_poll(1, t + 63'd2));
        send_poll(card_poll(1, t + 63'd2 + 63'hFFFF_FFFF));
        send_poll(card_poll(1, t + 63'd3 + 63'hFFFF_FFFF));
        repeat (3) send_poll(empty_poll(t + 63'd4 + 63'hFFFF_FFFF));
        drain();
        load_config('{dedup_window_us: RST_DEDUP_WINDOW, idle_forget_count: 8'd2,
                      base_interval_ms: 16'd1, slow_idle_threshold: 8'd2,
                      slower_idle_threshold: COUNT_MAX});
        repeat (3) send_poll(empty_poll(t + 63'd5 + 63'hFFFF_FFFF));
        poll_clock = t + 63'd6 + 63'hFFFF_FFFF;
    endtask

    task automatic test_idle_saturation();
        drain();
        gap_max = $urandom_range(0, 4);
        stall_max = $urandom_range(0, 12);
        load_config('{dedup_window_us: 32'd1000, idle_forget_count: COUNT_MAX,
                      base_interval_ms: INTERVAL_W'($urandom_range(1, 65535)),
                      slow_idle_threshold: COUNT_MAX - 8'd1, slower_idle_threshold: COUNT_MAX});
        new_card(0);
        send_poll(card_poll(0, poll_clock));
        repeat (300) begin
            poll_clock += TIME_W'($urandom_range(0, 50));
            send_poll(empty_poll(poll_clock));
        end
        send_poll(card_poll(0, poll_clock));
    endtask

    task automatic test_random_sessions(input int phases, input int per_phase);
        int    sent, pick, run, slot;
        t_item p;
        for (int ph = 0; ph < phases; ph++) begin
            drain();
            load_config(random_config());
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            for (int s = 0; s < 4; s++) new_card(s);
            if (card_len[0] > 4'd4) begin
                card_lo[3] = card_lo[0] & 64'hFFFF_FFFF;
                card_hi[3] = '0;
                card_len[3] = 4'd4;
            end
            if ($urandom_range(0, 3) == 0) poll_clock = TIME_W'({$urandom, $urandom});
            sent = 0;
            while (sent < per_phase) begin
                pick = $urandom_range(0, 99);
                slot = $urandom_range(0, 3);
                if (pick < 24) begin
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 45)
                                                      : $urandom_range(1, 4);
                    repeat (run) begin
                        poll_clock += TIME_W'($urandom_range(0, 400000));
                        send_poll(empty_poll(poll_clock));
                    end
                    sent += run;
                end else begin
                    if (pick < 62) begin
                        poll_clock += time_step();
                        p = card_poll(slot, poll_clock);
                    end else if (pick < 74) begin
                        // same UID right at and just past the window
                        poll_clock = TIME_W'(last_report + cfg.dedup_window_us +
                                             $urandom_range(0, 1));
                        p = make_poll(1'b1, card_sak[slot], last_lo, last_hi, last_len, poll_clock);
                    end else if (pick < 86) begin
                        poll_clock += time_step();
                        p = make_poll(1'b1, SAK_W'($urandom), {$urandom, $urandom},
                                      UID_HI_W'($urandom), UID_LEN_W'($urandom_range(0, 15)),
                                      poll_clock);
                    end else if (pick < 94) begin
                        poll_clock -= TIME_W'($urandom_range(0, 5000));
                        p = card_poll(slot, poll_clock);
                    end else begin
                        poll_clock = TIME_W'({$urandom, $urandom});
                        p = card_poll(slot, poll_clock);
                    end
                    if ($urandom_range(0, 19) == 0) new_card(slot);
                    send_poll(p);
                    sent++;
                end
            end
        end
    endtask

    // receiver: ready runs broken by stall runs of random length
    int ready_hold = 0;
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold--;
        end else if (stall_max != 0 && i_ready && $urandom_range(0, 2) == 0) begin
            i_ready <= 1'b0;
            ready_hold = $urandom_range(0, stall_max);
        end else begin
            i_ready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result transfer with nothing outstanding", $time);
                n_errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("card_event", want.card_event, o_card_event);
                check_field("card_kind", want.card_kind, o_card_kind);
                check_field("event_uid_low", want.event_uid_low, o_event_uid_low);
                check_field("event_uid_high", want.event_uid_high, o_event_uid_high);
                check_field("event_uid_length", want.event_uid_length, o_event_uid_length);
                check_field("next_delay_ms", want.next_delay_ms, o_next_delay_ms);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        cfg = '{dedup_window_us: RST_DEDUP_WINDOW, idle_forget_count: RST_IDLE_FORGET,
                base_interval_ms: RST_POLL_INTERVAL, slow_idle_threshold: RST_SLOW_IDLE,
                slower_idle_threshold: RST_SLOWER_IDLE};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_extremes();
        test_idle_saturation();
        test_random_sessions(10, 112);
        drain();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/cedpb_pkg.sv
sv/cedpb_cfg.sv
sv/cedpb_eval.sv
sv/card_event_dedup_and_poll_backoff.sv
bench/tb_card_event_dedup_and_poll_backoff.sv
